// ===== src/lstp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and arithmetic helpers of the lidar point converter.
// No dependencies.
package lstp_pkg;

    localparam logic [2:0] CFG_ANGLE_START = 3'd0;
    localparam logic [2:0] CFG_ANGLE_STEP  = 3'd1;
    localparam logic [2:0] CFG_MOTOR_STEP  = 3'd2;
    localparam logic [2:0] CFG_OFFSET_X    = 3'd3;
    localparam logic [2:0] CFG_OFFSET_Y    = 3'd4;
    localparam logic [2:0] CFG_ROT_QUAT    = 3'd5;
    localparam logic [2:0] CFG_TRANSLATION = 3'd6;
    localparam logic [2:0] CFG_SPIKE_THR   = 3'd7;

    localparam int COORD_BITS = 18;

    typedef struct packed {
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] motor_step;
        logic [15:0] horiz_off_x;
        logic [15:0] horiz_off_y;
        logic [63:0] rotation_quat;
        logic [47:0] translation_xyz;
        logic [15:0] spike_threshold;
    } t_cfg;

    function automatic logic signed [33:0] atan_val(input logic [3:0] i);
        logic signed [33:0] v;
        begin
            case (i)
                4'd0:    v = 34'sd536870912;
                4'd1:    v = 34'sd316933406;
                4'd2:    v = 34'sd167458907;
                4'd3:    v = 34'sd85004756;
                4'd4:    v = 34'sd42667331;
                4'd5:    v = 34'sd21354465;
                4'd6:    v = 34'sd10679838;
                4'd7:    v = 34'sd5340245;
                4'd8:    v = 34'sd2670163;
                4'd9:    v = 34'sd1335087;
                4'd10:   v = 34'sd667544;
                4'd11:   v = 34'sd333772;
                4'd12:   v = 34'sd166886;
                4'd13:   v = 34'sd83443;
                4'd14:   v = 34'sd41722;
                default: v = 34'sd20861;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [39:0] v);
        logic signed [COORD_BITS-1:0] r;
        begin
            if (v > 40'sd131071) begin
                r = 18'sd131071;
            end else if (v < -40'sd131072) begin
                r = -18'sd131072;
            end else begin
                r = v[COORD_BITS-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== src/lidar_scan_to_points.sv =====
`timescale 1ns / 1ps
// Lidar range samples to 3-D points: spike filter, job queue, point engine.
// A sample's point is queued once the next sample arrives, or at once if it ends a scan;
// the point engine then converts it (two 16-step CORDIC passes, 22 three-digit multiplies).
// The engine works on one point at a time with its shared CORDIC and multiplier; a bare
// end-of-scan marker skips both. Synchronous reset clears held samples, queue and output;
// registers return to their reset values. Depends on lstp_pkg, lstp_front, lstp_fifo, lstp_back.
module lidar_scan_to_points #(
    parameter int RANGE_BITS = 16,
    parameter int INDEX_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // range_mm, sample_index, zero fill
    input  logic [((RANGE_BITS+INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // point_x, point_y, point_z, point_index, zero fill
    output logic [((54+INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
    // point_present
    output logic                m_axis_tuser,
    output logic                m_axis_tlast
);
    localparam int JOB_BITS = RANGE_BITS + INDEX_BITS + 2;
    localparam int OUT_W    = ((54 + INDEX_BITS + 7) / 8) * 8;

    lstp_pkg::t_cfg        r_cfg;
    logic                  c_push, c_full, c_jvalid, c_pop;
    logic [JOB_BITS-1:0]   c_job_in, c_job_out;
    logic signed [17:0]    c_x, c_y, c_z;
    logic [INDEX_BITS-1:0] c_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start     <= 16'd0;
            r_cfg.angle_step      <= 16'd0;
            r_cfg.motor_step      <= 16'd0;
            r_cfg.horiz_off_x     <= 16'd0;
            r_cfg.horiz_off_y     <= 16'd0;
            r_cfg.rotation_quat   <= 64'h0000_0000_4000_0000;
            r_cfg.translation_xyz <= 48'd0;
            r_cfg.spike_threshold <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lstp_pkg::CFG_ANGLE_START: r_cfg.angle_start     <= i_cfg_data[15:0];
                lstp_pkg::CFG_ANGLE_STEP:  r_cfg.angle_step      <= i_cfg_data[15:0];
                lstp_pkg::CFG_MOTOR_STEP:  r_cfg.motor_step      <= i_cfg_data[15:0];
                lstp_pkg::CFG_OFFSET_X:    r_cfg.horiz_off_x     <= i_cfg_data[15:0];
                lstp_pkg::CFG_OFFSET_Y:    r_cfg.horiz_off_y     <= i_cfg_data[15:0];
                lstp_pkg::CFG_ROT_QUAT:    r_cfg.rotation_quat   <= i_cfg_data;
                lstp_pkg::CFG_TRANSLATION: r_cfg.translation_xyz <= i_cfg_data[47:0];
                lstp_pkg::CFG_SPIKE_THR:   r_cfg.spike_threshold <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    lstp_front #(
        .RANGE_BITS (RANGE_BITS),
        .INDEX_BITS (INDEX_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_thr   (r_cfg.spike_threshold),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_range (s_axis_tdata[RANGE_BITS-1:0]),
        .i_index (s_axis_tdata[RANGE_BITS +: INDEX_BITS]),
        .i_end   (s_axis_tlast),
        .o_push  (c_push),
        .o_job   (c_job_in),
        .i_full  (c_full)
    );

    lstp_fifo #(
        .WIDTH (JOB_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_data  (c_job_in),
        .o_full  (c_full),
        .i_pop   (c_pop),
        .o_valid (c_jvalid),
        .o_data  (c_job_out)
    );

    lstp_back #(
        .RANGE_BITS (RANGE_BITS),
        .INDEX_BITS (INDEX_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (c_jvalid),
        .i_job       (c_job_out),
        .o_pop       (c_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_x         (c_x),
        .o_y         (c_y),
        .o_z         (c_z),
        .o_index     (c_idx),
        .o_present   (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({c_idx, c_z, c_y, c_x});
endmodule

// ===== src/lstp_fifo.sv =====
`timescale 1ns / 1ps
// Four-entry job queue between the sample filter and the point engine.
// No dependencies.
module lstp_fifo #(
    parameter int WIDTH = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       c_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    assign c_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (c_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, c_pop};
        end
    end
endmodule

// ===== src/lstp_front.sv =====
`timescale 1ns / 1ps
// Sample filter: holds one sample for the spike test and issues point jobs.
// No dependencies.
module lstp_front #(
    parameter int RANGE_BITS = 16,
    parameter int INDEX_BITS = 12,
    parameter int JOB_BITS   = RANGE_BITS + INDEX_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_thr,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [RANGE_BITS-1:0] i_range,
    input  logic [INDEX_BITS-1:0] i_index,
    input  logic                  i_end,
    output logic                  o_push,
    output logic [JOB_BITS-1:0]   o_job,
    input  logic                  i_full
);
    localparam int DW = ((RANGE_BITS > 16) ? RANGE_BITS : 16) + 1;
    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_PUSH0 = 2'd1;
    localparam logic [1:0] F_PUSH1 = 2'd2;

    logic [1:0]            r_state;
    logic [RANGE_BITS-1:0] r_held_range;
    logic [RANGE_BITS-1:0] r_left_range;
    logic [INDEX_BITS-1:0] r_held_index;
    logic                  r_held_valid;
    logic                  r_held_first;
    logic                  r_v0;
    logic                  r_v1;
    logic [JOB_BITS-1:0]   r_job0;
    logic [JOB_BITS-1:0]   r_job1;

    logic [RANGE_BITS-1:0] c_dl;
    logic [RANGE_BITS-1:0] c_dr;
    logic [DW-1:0]         c_sum;
    logic                  c_keep;
    logic                  c_acc;

    assign o_ready = (r_state == F_IDLE);
    assign c_acc   = i_valid && o_ready;

    always_comb begin
        c_dl   = (r_held_range > r_left_range) ? r_held_range - r_left_range
                                               : r_left_range - r_held_range;
        c_dr   = (r_held_range > i_range) ? r_held_range - i_range : i_range - r_held_range;
        c_sum  = DW'(c_dl) + DW'(c_dr);
        c_keep = r_held_valid && (r_held_range != '0)
                 && (r_held_first || (c_sum <= DW'(i_thr)));
    end

    always_comb begin
        o_push = 1'b0;
        o_job  = r_job0;
        unique case (r_state)
            F_PUSH0: begin
                o_push = r_v0 && !i_full;
            end
            F_PUSH1: begin
                o_push = r_v1 && !i_full;
                o_job  = r_job1;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_acc) begin
            r_job0 <= {r_held_range, r_held_index, 1'b0, 1'b1};
            r_job1 <= {i_range, i_index, 1'b1, (i_range != '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_held_range <= '0;
            r_left_range <= '0;
            r_held_index <= '0;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (c_acc) begin
                        r_v0    <= c_keep;
                        r_v1    <= i_end;
                        r_state <= F_PUSH0;
                        if (i_end) begin
                            r_held_range <= '0;
                            r_left_range <= '0;
                            r_held_index <= '0;
                            r_held_valid <= 1'b0;
                            r_held_first <= 1'b0;
                        end else begin
                            r_left_range <= r_held_range;
                            r_held_range <= i_range;
                            r_held_index <= i_index;
                            r_held_first <= !r_held_valid;
                            r_held_valid <= 1'b1;
                        end
                    end
                end
                F_PUSH0: begin
                    if (!r_v0 || !i_full) begin
                        r_state <= F_PUSH1;
                    end
                end
                F_PUSH1: begin
                    if (!r_v1 || !i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== src/lstp_back.sv =====
`timescale 1ns / 1ps
// Point engine: shared CORDIC and digit-serial multiplier, rotation, output register.
// Depends on lstp_pkg.
module lstp_back #(
    parameter int RANGE_BITS = 16,
    parameter int INDEX_BITS = 12,
    parameter int JOB_BITS   = RANGE_BITS + INDEX_BITS + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lstp_pkg::t_cfg              i_cfg,
    input  logic                        i_job_valid,
    input  logic [JOB_BITS-1:0]         i_job,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [17:0]          o_x,
    output logic signed [17:0]          o_y,
    output logic signed [17:0]          o_z,
    output logic [INDEX_BITS-1:0]       o_index,
    output logic                        o_present,
    output logic                        o_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORD = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [4:0] OP_REACH  = 5'd0;
    localparam logic [4:0] OP_PX     = 5'd1;
    localparam logic [4:0] OP_PY     = 5'd2;
    localparam logic [4:0] OP_PZ     = 5'd3;
    localparam logic [4:0] OP_QFIRST = 5'd4;
    localparam logic [4:0] OP_QLAST  = 5'd12;
    localparam logic [4:0] OP_MFIRST = 5'd13;
    localparam logic [4:0] OP_MLAST  = 5'd21;

    logic [2:0]                r_state;
    logic [RANGE_BITS-1:0]     r_range;
    logic [INDEX_BITS-1:0]     r_idx;
    logic                      r_last;
    logic                      r_present;
    logic signed [17:0]        r_sa, r_ca, r_sm, r_cm;
    logic signed [47:0]        r_reach, r_px, r_py, r_pz;
    logic signed [31:0]        r_qp [9];
    logic signed [71:0]        r_acc [3];
    logic [4:0]                r_op;
    logic [1:0]                r_row, r_col, r_dig;
    logic signed [47:0]        r_ma, r_mb;
    logic signed [95:0]        r_prod;
    logic signed [33:0]        r_cx, r_cy, r_ct;
    logic                      r_flip;
    logic [3:0]                r_it;
    logic                      r_cidx;
    logic                      r_ovalid;
    logic signed [17:0]        r_ox, r_oy, r_oz;
    logic [INDEX_BITS-1:0]     r_oidx;
    logic                      r_opres, r_olast;

    logic [RANGE_BITS-1:0]     c_jrange;
    logic [INDEX_BITS-1:0]     c_jidx;
    logic [15:0]               c_beam;
    logic [31:0]               c_ang;
    logic signed [33:0]        c_t0, c_t;
    logic                      c_flip;
    logic signed [33:0]        c_dx, c_dy, c_nx, c_ny, c_nt, c_fx, c_fy;
    logic signed [33:0]        c_cr, c_sr;
    logic signed [16:0]        c_d;
    logic signed [64:0]        c_part;
    logic signed [95:0]        c_pext, c_psh;
    logic signed [15:0]        c_qx, c_qy, c_qz, c_qw;
    logic signed [34:0]        c_m;
    logic signed [47:0]        c_a, c_b, c_pcol;
    logic [3:0]                c_qi;
    logic signed [95:0]        c_rnd28, c_rnd12;
    logic signed [71:0]        c_v [3];
    logic signed [17:0]        c_o [3];
    logic                      c_load_out;

    assign c_jrange = i_job[JOB_BITS-1 -: RANGE_BITS];
    assign c_jidx   = i_job[INDEX_BITS+1:2];
    assign o_pop    = (r_state == S_IDLE) && i_job_valid;

    assign c_beam = i_cfg.angle_start + 16'(16'(c_jidx) * i_cfg.angle_step);
    assign c_ang  = (r_state == S_IDLE) ? {c_beam, 16'd0}
                                        : 32'd0 - {i_cfg.motor_step[11:0], 20'd0};

    always_comb begin
        c_t0   = 34'($signed(c_ang));
        c_t    = c_t0;
        c_flip = 1'b0;
        if (c_t0 > 34'sd1073741824) begin
            c_t    = c_t0 - 34'sd2147483648;
            c_flip = 1'b1;
        end else if (c_t0 < -34'sd1073741824) begin
            c_t    = c_t0 + 34'sd2147483648;
            c_flip = 1'b1;
        end
    end

    always_comb begin
        c_dx = r_cy >>> r_it;
        c_dy = r_cx >>> r_it;
        if (r_ct >= 0) begin
            c_nx = r_cx - c_dx;
            c_ny = r_cy + c_dy;
            c_nt = r_ct - lstp_pkg::atan_val(r_it);
        end else begin
            c_nx = r_cx + c_dx;
            c_ny = r_cy - c_dy;
            c_nt = r_ct + lstp_pkg::atan_val(r_it);
        end
        c_fx = r_flip ? -c_nx : c_nx;
        c_fy = r_flip ? -c_ny : c_ny;
        c_cr = (c_fx + 34'sd8192) >>> 14;
        c_sr = (c_fy + 34'sd8192) >>> 14;
    end

    always_comb begin
        case (r_dig)
            2'd0:    c_d = $signed({1'b0, r_mb[15:0]});
            2'd1:    c_d = $signed({1'b0, r_mb[31:16]});
            default: c_d = $signed({r_mb[47], r_mb[47:32]});
        endcase
        c_part = r_ma * c_d;
        c_pext = 96'(c_part);
        case (r_dig)
            2'd0:    c_psh = c_pext;
            2'd1:    c_psh = c_pext <<< 16;
            default: c_psh = c_pext <<< 32;
        endcase
    end

    assign c_qx = $signed(i_cfg.rotation_quat[15:0]);
    assign c_qy = $signed(i_cfg.rotation_quat[31:16]);
    assign c_qz = $signed(i_cfg.rotation_quat[47:32]);
    assign c_qw = $signed(i_cfg.rotation_quat[63:48]);
    assign c_qi = 4'(r_op - OP_QFIRST);

    always_comb begin
        case ({r_row, r_col})
            4'h0: c_m = 35'sd268435456 - ((35'(r_qp[1]) + 35'(r_qp[2])) <<< 1);
            4'h1: c_m = (35'(r_qp[3]) - 35'(r_qp[8])) <<< 1;
            4'h2: c_m = (35'(r_qp[4]) + 35'(r_qp[7])) <<< 1;
            4'h4: c_m = (35'(r_qp[3]) + 35'(r_qp[8])) <<< 1;
            4'h5: c_m = 35'sd268435456 - ((35'(r_qp[0]) + 35'(r_qp[2])) <<< 1);
            4'h6: c_m = (35'(r_qp[5]) - 35'(r_qp[6])) <<< 1;
            4'h8: c_m = (35'(r_qp[4]) - 35'(r_qp[7])) <<< 1;
            4'h9: c_m = (35'(r_qp[5]) + 35'(r_qp[6])) <<< 1;
            default: c_m = 35'sd268435456 - ((35'(r_qp[0]) + 35'(r_qp[1])) <<< 1);
        endcase
        case (r_col)
            2'd0:    c_pcol = r_px;
            2'd1:    c_pcol = r_py;
            default: c_pcol = r_pz;
        endcase
    end

    always_comb begin
        c_a = 48'(c_m);
        c_b = c_pcol;
        case (r_op) inside
            OP_REACH: begin
                c_a = $signed(48'(r_range));
                c_b = 48'(r_sa);
            end
            OP_PX: begin
                c_a = r_reach + (48'($signed(i_cfg.horiz_off_x)) <<< 16);
                c_b = 48'(r_cm);
            end
            OP_PY: begin
                c_a = r_reach + (48'($signed(i_cfg.horiz_off_y)) <<< 16);
                c_b = 48'(r_sm);
            end
            OP_PZ: begin
                c_a = $signed(48'(r_range));
                c_b = 48'(r_ca);
            end
            [OP_QFIRST:OP_QLAST]: begin
                case (c_qi)
                    4'd0:    begin c_a = 48'(c_qx); c_b = 48'(c_qx); end
                    4'd1:    begin c_a = 48'(c_qy); c_b = 48'(c_qy); end
                    4'd2:    begin c_a = 48'(c_qz); c_b = 48'(c_qz); end
                    4'd3:    begin c_a = 48'(c_qx); c_b = 48'(c_qy); end
                    4'd4:    begin c_a = 48'(c_qx); c_b = 48'(c_qz); end
                    4'd5:    begin c_a = 48'(c_qy); c_b = 48'(c_qz); end
                    4'd6:    begin c_a = 48'(c_qx); c_b = 48'(c_qw); end
                    4'd7:    begin c_a = 48'(c_qy); c_b = 48'(c_qw); end
                    default: begin c_a = 48'(c_qz); c_b = 48'(c_qw); end
                endcase
            end
            default: begin
                c_a = 48'(c_m);
                c_b = c_pcol;
            end
        endcase
    end

    assign c_rnd28 = r_prod + 96'sd134217728;
    assign c_rnd12 = r_prod + 96'sd2048;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_v[k] = r_acc[k]
                     + (72'($signed(i_cfg.translation_xyz[16*k +: 16])) <<< 32)
                     + 72'sd2147483648;
            c_o[k] = r_present ? lstp_pkg::sat_coord(c_v[k][71:32]) : 18'sd0;
        end
    end

    assign c_load_out = (r_state == S_FIN) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (c_load_out) begin
            r_ox    <= c_o[0];
            r_oy    <= c_o[1];
            r_oz    <= c_o[2];
            r_oidx  <= r_idx;
            r_opres <= r_present;
            r_olast <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_op     <= OP_REACH;
            r_row    <= 2'd0;
            r_col    <= 2'd0;
            r_dig    <= 2'd0;
            r_it     <= 4'd0;
            r_cidx   <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_range   <= c_jrange;
                        r_idx     <= c_jidx;
                        r_last    <= i_job[1];
                        r_present <= i_job[0];
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_cx   <= 34'sd652032874;
                        r_cy   <= 34'sd0;
                        r_ct   <= c_t;
                        r_flip <= c_flip;
                        r_it   <= 4'd0;
                        r_cidx <= 1'b0;
                        r_op   <= OP_REACH;
                        r_row  <= 2'd0;
                        r_col  <= 2'd0;
                        r_state <= i_job[0] ? S_CORD : S_FIN;
                    end
                end
                S_CORD: begin
                    r_cx <= c_nx;
                    r_cy <= c_ny;
                    r_ct <= c_nt;
                    r_it <= r_it + 4'd1;
                    if (r_it == 4'd15) begin
                        if (!r_cidx) begin
                            r_ca   <= c_cr[17:0];
                            r_sa   <= c_sr[17:0];
                            r_cx   <= 34'sd652032874;
                            r_cy   <= 34'sd0;
                            r_ct   <= c_t;
                            r_flip <= c_flip;
                            r_cidx <= 1'b1;
                        end else begin
                            r_cm    <= c_cr[17:0];
                            r_sm    <= c_sr[17:0];
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_ma    <= c_a;
                    r_mb    <= c_b;
                    r_prod  <= '0;
                    r_dig   <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= r_prod + c_psh;
                    r_dig  <= r_dig + 2'd1;
                    if (r_dig == 2'd2) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    case (r_op) inside
                        OP_REACH: r_reach <= r_prod[47:0];
                        OP_PX:    r_px    <= c_rnd28[75:28];
                        OP_PY:    r_py    <= c_rnd28[75:28];
                        OP_PZ:    r_pz    <= c_rnd12[59:12];
                        [OP_QFIRST:OP_QLAST]: r_qp[c_qi] <= r_prod[31:0];
                        default: begin
                            r_acc[r_row] <= r_acc[r_row] + r_prod[71:0];
                            if (r_col == 2'd2) begin
                                r_col <= 2'd0;
                                r_row <= r_row + 2'd1;
                            end else begin
                                r_col <= r_col + 2'd1;
                            end
                        end
                    endcase
                    r_op    <= r_op + 5'd1;
                    r_state <= (r_op == OP_MLAST) ? S_FIN : S_LOAD;
                end
                S_FIN: begin
                    if (c_load_out) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_ovalid;
    assign o_x       = r_ox;
    assign o_y       = r_oy;
    assign o_z       = r_oz;
    assign o_index   = r_oidx;
    assign o_present = r_opres;
    assign o_last    = r_olast;
endmodule

// ===== tb/tb_lidar_scan_to_points.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lidar_scan_to_points: drives range samples, predicts the
// filtered and converted points, and checks every output transfer. Depends on lstp_pkg.
module tb_lidar_scan_to_points;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CORDIC_ATAN [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic [15:0] range_mm;
        logic [11:0] index;
        logic        scan_end;
    } t_sample;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [11:0]        index;
        logic               present;
        logic               last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = lstp_pkg::CFG_ANGLE_START;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // range_mm, sample_index, zero fill
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // point_x, point_y, point_z, point_index, zero fill
    logic        m_axis_tuser;        // point_present
    logic        m_axis_tlast;

    lidar_scan_to_points u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copy
    logic [15:0] angle_start = 16'd0, angle_step = 16'd0, motor_step = 16'd0;
    logic [15:0] horiz_off_x = 16'd0, horiz_off_y = 16'd0, spike_thr = 16'd1000;
    logic [63:0] rot_quat = 64'h4000_0000;
    logic [47:0] translation = '0;

    // spike filter state
    logic [15:0] held_range = '0, left_range = '0;
    logic [11:0] held_index = '0;
    logic        held_valid = 1'b0, held_is_first = 1'b0;

    t_sample pending_samples[$];
    t_point  expected_points[$];
    int      mismatches = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    int      quiet_cycles = 0;

    function automatic void cordic_sin_cos(input logic [31:0] ang, output longint s,
                                           output longint c);
        longint t, x, y, dx, dy;
        bit flip;
        int i;
        t = longint'($signed(ang));
        x = 652032874;
        y = 0;
        flip = 0;
        if (t > 64'sd1073741824) begin
            t -= 64'sd2147483648;
            flip = 1;
        end else if (t < -64'sd1073741824) begin
            t += 64'sd2147483648;
            flip = 1;
        end
        for (i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
                x -= dx; y += dy; t -= CORDIC_ATAN[i];
            end else begin
                x += dx; y -= dy; t += CORDIC_ATAN[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
    endfunction

    function automatic logic signed [17:0] clamp_mm(input longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[17:0];
    endfunction

    function automatic t_point convert_sample(input logic [15:0] r, input logic [11:0] idx,
                                              input logic last);
        logic [15:0] beam;
        logic [31:0] sweep;
        longint sa, ca, sm, cm, reach, px, py, pz, qx, qy, qz, qw, acc;
        longint m [9];
        longint p [3];
        t_point pt;
        int k;
        beam = angle_start + idx * angle_step;
        sweep = 32'd0 - {motor_step[11:0], 20'd0};
        cordic_sin_cos({beam, 16'd0}, sa, ca);
        cordic_sin_cos(sweep, sm, cm);
        reach = longint'(r) * sa;
        px = ((reach + longint'($signed(horiz_off_x)) * 65536) * cm + 134217728) >>> 28;
        py = ((reach + longint'($signed(horiz_off_y)) * 65536) * sm + 134217728) >>> 28;
        pz = (longint'(r) * ca + 2048) >>> 12;
        qx = longint'($signed(rot_quat[15:0]));
        qy = longint'($signed(rot_quat[31:16]));
        qz = longint'($signed(rot_quat[47:32]));
        qw = longint'($signed(rot_quat[63:48]));
        m[0] = 268435456 - 2 * (qy * qy + qz * qz);
        m[1] = 2 * (qx * qy - qz * qw);
        m[2] = 2 * (qx * qz + qy * qw);
        m[3] = 2 * (qx * qy + qz * qw);
        m[4] = 268435456 - 2 * (qx * qx + qz * qz);
        m[5] = 2 * (qy * qz - qx * qw);
        m[6] = 2 * (qx * qz - qy * qw);
        m[7] = 2 * (qy * qz + qx * qw);
        m[8] = 268435456 - 2 * (qx * qx + qy * qy);
        for (k = 0; k < 3; k++) begin
            acc = m[3*k] * px + m[3*k+1] * py + m[3*k+2] * pz;
            acc += longint'($signed(translation[16*k +: 16])) * 64'sd4294967296
                   + 64'sd2147483648;
            p[k] = acc >>> 32;
        end
        pt.x = clamp_mm(p[0]);
        pt.y = clamp_mm(p[1]);
        pt.z = clamp_mm(p[2]);
        pt.index = idx;
        pt.present = 1'b1;
        pt.last = last;
        return pt;
    endfunction

    function automatic void filter_sample(input logic [15:0] r, input logic [11:0] idx,
                                          input logic scan_end);
        bit keep;
        int unsigned dl, dr;
        t_point marker;
        if (held_valid) begin
            keep = held_range != 0;
            if (keep && !held_is_first) begin
                dl = held_range > left_range ? held_range - left_range
                                             : left_range - held_range;
                dr = held_range > r ? held_range - r : r - held_range;
                if (dl + dr > spike_thr) keep = 0;
            end
            if (keep) begin
                expected_points.insert(expected_points.size(),
                                       convert_sample(held_range, held_index, 1'b0));
            end
        end
        if (scan_end) begin
            if (r != 0) begin
                expected_points.insert(expected_points.size(), convert_sample(r, idx, 1'b1));
            end else begin
                marker = '{x: '0, y: '0, z: '0, index: idx, present: 1'b0, last: 1'b1};
                expected_points.insert(expected_points.size(), marker);
            end
            held_range = '0;
            left_range = '0;
            held_index = '0;
            held_valid = 1'b0;
            held_is_first = 1'b0;
        end else begin
            left_range = held_range;
            held_range = r;
            held_index = idx;
            held_is_first = !held_valid;
            held_valid = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d (t=%0t)", field, got, want, $realtime);
        mismatches++;
    endtask

    // driver: predict on each accepted transfer, then load the next sample
    always @(posedge i_clk) begin
        t_sample smp;
        if (s_axis_tvalid && s_axis_tready)
            filter_sample(s_axis_tdata[15:0], s_axis_tdata[27:16], s_axis_tlast);
        if (!s_axis_tvalid || s_axis_tready) begin
            if (i_rst_n && pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
                smp = pending_samples.pop_front();
                s_axis_tdata <= {4'd0, smp.index, smp.range_mm};
                s_axis_tlast <= smp.scan_end;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_point want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = expected_points.pop_front();
                if ($signed(m_axis_tdata[17:0]) != want.x)
                    report_mismatch("x", $signed(m_axis_tdata[17:0]), want.x);
                if ($signed(m_axis_tdata[35:18]) != want.y)
                    report_mismatch("y", $signed(m_axis_tdata[35:18]), want.y);
                if ($signed(m_axis_tdata[53:36]) != want.z)
                    report_mismatch("z", $signed(m_axis_tdata[53:36]), want.z);
                if (m_axis_tdata[65:54] != want.index)
                    report_mismatch("index", m_axis_tdata[65:54], want.index);
                if (m_axis_tuser != want.present)
                    report_mismatch("present", m_axis_tuser, want.present);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            lstp_pkg::CFG_ANGLE_START: angle_start = value[15:0];
            lstp_pkg::CFG_ANGLE_STEP:  angle_step = value[15:0];
            lstp_pkg::CFG_MOTOR_STEP:  motor_step = value[15:0];
            lstp_pkg::CFG_OFFSET_X:    horiz_off_x = value[15:0];
            lstp_pkg::CFG_OFFSET_Y:    horiz_off_y = value[15:0];
            lstp_pkg::CFG_ROT_QUAT:    rot_quat = value;
            lstp_pkg::CFG_TRANSLATION: translation = value[47:0];
            lstp_pkg::CFG_SPIKE_THR:   spike_thr = value[15:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input int r, input int idx, input bit scan_end);
        t_sample smp;
        smp.range_mm = r[15:0];
        smp.index = idx[11:0];
        smp.scan_end = scan_end;
        pending_samples.insert(pending_samples.size(), smp);
    endtask

    // one scan: smooth ranges with zeros, spikes and full-range values mixed in
    task automatic add_scan(input int len);
        int idx, r, k, sel;
        idx = ($urandom_range(3) == 0) ? $urandom_range(4095) : 0;
        r = $urandom_range(200, 30000);
        for (k = 0; k < len; k++) begin
            sel = $urandom_range(99);
            if (sel < 8) r = 0;
            else if (sel < 16) r = $urandom_range(65535);
            else if (sel < 20) r = 65535;
            else if (r == 0 || r > 60000) r = $urandom_range(200, 30000);
            else r = r + $urandom_range(600) - 300;
            if (r < 0) r = 1;
            add_sample(r, ($urandom_range(19) == 0) ? $urandom_range(4095) : idx,
                       k == len - 1);
            idx++;
            if (sel >= 16 && sel < 20) r = $urandom_range(200, 30000);
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16(input int phase);
        if (phase == 1) return 16'h8000;
        if (phase == 2) return 16'h7FFF;
        return 16'($urandom());
    endfunction

    initial begin
        int phase;
        logic [63:0] quat;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples with reset registers
        add_sample(65535, 4095, 1);
        add_sample(0, 0, 1);
        add_sample(1, 0, 0);
        add_sample(500, 1, 0);
        add_sample(20000, 2, 0);
        add_sample(510, 3, 0);
        add_sample(0, 4, 0);
        add_sample(520, 5, 0);
        add_sample(530, 6, 0);
        add_sample(0, 7, 1);
        add_sample(1000, 10, 0);
        add_sample(1000, 10, 0);
        add_sample(2001, 11, 0);
        add_sample(1000, 12, 0);
        add_sample(4095, 0, 1);
        add_sample(0, 100, 0);
        add_sample(300, 101, 1);
        add_sample(40000, 3000, 0);
        add_sample(65535, 4095, 1);
        wait_drained();

        for (phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 47; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 47; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            write_reg(lstp_pkg::CFG_ANGLE_START, {48'd0, pick16(phase)});
            write_reg(lstp_pkg::CFG_ANGLE_STEP, {48'd0, (phase == 0) ? 16'd0 : pick16(phase)});
            write_reg(lstp_pkg::CFG_MOTOR_STEP, {48'd0, pick16(phase)});
            write_reg(lstp_pkg::CFG_OFFSET_X, {48'd0, pick16(phase)});
            write_reg(lstp_pkg::CFG_OFFSET_Y, {48'd0, pick16(phase)});
            case (phase % 5)
                0: quat = 64'h4000_0000;
                1: quat = 64'h8000_8000_8000_8000;
                2: quat = 64'h7FFF_7FFF_7FFF_7FFF;
                3: quat = 64'h2D41_0000_0000_2D41;
                default: quat = {$urandom(), $urandom()};
            endcase
            write_reg(lstp_pkg::CFG_ROT_QUAT, quat);
            write_reg(lstp_pkg::CFG_TRANSLATION,
                      (phase == 1) ? 64'h0000_8000_8000_8000 :
                      (phase == 2) ? 64'h0000_7FFF_7FFF_7FFF :
                      {16'd0, 16'($urandom()), $urandom()});
            write_reg(lstp_pkg::CFG_SPIKE_THR,
                      (phase == 1) ? 64'd0 : (phase == 2) ? 64'hFFFF :
                      64'($urandom_range(200, 5000)));
            while (pending_samples.size() < 105) add_scan($urandom_range(1, 14));
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
